[hw/rtl/catk_pkg.sv]
`timescale 1ns / 1ps

package catk_pkg;

  // fixed field widths of the item and result payloads
  localparam int KIND_W  = 2;
  localparam int CID_W   = 2;
  localparam int AID_W   = 3;
  localparam int DLY_W   = 16;
  localparam int ACT_W   = 2;
  localparam int TGT_W   = 8;
  localparam int EVT_W   = 32;
  localparam int MOD_W   = 16;

  // configuration port
  localparam int NUM_CFG   = 4;
  localparam int CFG_IDX_W = 2;
  localparam logic [MOD_W-1:0] MOD_RESET = 16'hFFFF;

  // at most this many results per tick
  localparam int MAX_RESULTS = 8;
  localparam int RCNT_W      = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK   = 2'd0,
    KIND_ARM    = 2'd1,
    KIND_CANCEL = 2'd2
  } kind_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_ACTIVATE  = 2'd0,
    ACT_SET_EVENT = 2'd1,
    ACT_CALLBACK  = 2'd2,
    ACT_INCREMENT = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_MOD,
    ST_READ,
    ST_UPDATE,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [AID_W-1:0] fired_alarm;
    logic [ACT_W-1:0] fired_action;
    logic [TGT_W-1:0] fired_target;
    logic [EVT_W-1:0] fired_event;
    logic             last;
  } result_t;

endpackage

[hw/rtl/catk_if.sv]
`timescale 1ns / 1ps

interface catk_cmd_if import catk_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CID_W-1:0]  counter_id;
  logic [AID_W-1:0]  alarm_id;
  logic [DLY_W-1:0]  alarm_delay;
  logic [DLY_W-1:0]  alarm_period;
  logic [ACT_W-1:0]  action_kind;
  logic [TGT_W-1:0]  action_target;
  logic [EVT_W-1:0]  event_mask;

  modport source (
    output valid, kind, counter_id, alarm_id, alarm_delay, alarm_period,
           action_kind, action_target, event_mask,
    input  ready
  );
  modport sink (
    input  valid, kind, counter_id, alarm_id, alarm_delay, alarm_period,
           action_kind, action_target, event_mask,
    output ready
  );
endinterface

interface catk_res_if import catk_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [AID_W-1:0] fired_alarm;
  logic [ACT_W-1:0] fired_action;
  logic [TGT_W-1:0] fired_target;
  logic [EVT_W-1:0] fired_event;
  logic             last;

  modport source (
    output valid, fired_alarm, fired_action, fired_target, fired_event, last,
    input  ready
  );
  modport sink (
    input  valid, fired_alarm, fired_action, fired_target, fired_event, last,
    output ready
  );
endinterface

[hw/rtl/counter_alarm_tick_engine.sv]
`timescale 1ns / 1ps

// channel   dir  handshake      payload
// cmd       in   valid/ready    kind, counter_id, alarm_id, alarm_delay, alarm_period,
//                               action_kind, action_target, event_mask
// res       out  valid/ready    fired_alarm, fired_action, fired_target, fired_event, last
// cfg       in   cfg_we         cfg_index, cfg_data (counter moduli)
//
// arm and cancel complete at the transfer and leave cmd.ready high
// a tick holds cmd.ready low for a counter step, plus a restoring remainder when the counter
// plus one reaches a nonzero modulus, plus a read of every alarm and an update of each active
// alarm, plus a flush step
// these steps follow from the single shared subtractor and the one read port of the alarm table
// rst is synchronous: counters cleared, all alarms inactive, moduli back to all ones
// a full result register stalls the alarm walk only when a second result is waiting,
// and holds the flush state while the final result waits

module counter_alarm_tick_engine import catk_pkg::*; #(
  parameter int NUM_COUNTERS = 4,
  parameter int NUM_ALARMS   = 8,
  parameter int TIME_BITS    = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MOD_W-1:0]     cfg_data,
  catk_cmd_if.sink             cmd,
  catk_res_if.source           res
);

  // counter value may run up to the modulus even when TIME_BITS is narrower
  localparam int CW  = (TIME_BITS > MOD_W) ? TIME_BITS : MOD_W;
  // value plus one, wrapping at 32 bits
  localparam int XW  = (CW < 32) ? CW + 1 : 32;
  localparam int SW  = XW;
  localparam int BW  = $clog2(XW);
  localparam int AW  = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
  localparam int CIW = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;

  typedef struct packed {
    logic [TIME_BITS-1:0] remaining;
    logic [TIME_BITS-1:0] reload;
    logic [CID_W-1:0]     counter;
    logic [ACT_W-1:0]     action;
    logic [TGT_W-1:0]     target;
    logic [EVT_W-1:0]     evt;
  } entry_t;

  state_t state, state_next;

  // configuration and counters
  logic [MOD_W-1:0]     cfg_mod [NUM_CFG];
  logic [CW-1:0]        cnt_val [NUM_COUNTERS];

  // alarm table: valid bits in flops, the rest in a memory with one write port and one read port
  logic                 active  [NUM_ALARMS];
  entry_t               mem     [NUM_ALARMS];
  entry_t               rd_q;

  // walk state
  logic [CID_W-1:0]     cur_cid;
  logic [AW-1:0]        idx;
  logic [RCNT_W-1:0]    res_cnt;
  logic [XW-1:0]        x_q;
  logic [MOD_W-1:0]     rem_q;
  logic [BW-1:0]        bit_cnt;

  // held result and output register
  result_t              pend, out_q, new_res;
  logic                 pend_vld, out_vld;

  // shared subtractor
  logic [SW-1:0]        sub_a, sub_b, sub_diff;
  logic                 sub_borrow;

  // decoded status
  logic                 cmd_fire, cid_ok, aid_ok, hit, expire, emit_ok;
  logic                 out_free, upd_stall, last_idx;
  logic [CIW-1:0]       ci;
  logic [AW-1:0]        aid_idx;
  logic [MOD_W-1:0]     modulus;
  logic [XW-1:0]        x_cmb;
  logic [MOD_W:0]       mod_in;
  logic [MOD_W-1:0]     rem_next;
  logic [TIME_BITS-1:0] dec;
  entry_t               arm_word;

  // control outputs of the sequencer
  logic                 cmd_ready, mem_we, act_set, act_clr, cnt_we;
  logic                 ld_x, mod_step, idx_inc, tick_start, emit_now, flush_now, out_load;
  logic [AW-1:0]        mem_wa, act_ia;
  entry_t               mem_wd;
  logic [CW-1:0]        cnt_wd;

  assign cmd_fire = cmd.valid & cmd.ready;
  assign cid_ok   = 32'(cur_cid) < NUM_COUNTERS;
  assign aid_ok   = 32'(cmd.alarm_id) < NUM_ALARMS;
  assign aid_idx  = AW'(cmd.alarm_id);
  assign ci       = CIW'(cur_cid);
  assign modulus  = cfg_mod[cur_cid];
  assign x_cmb    = XW'(cnt_val[ci]) + XW'(1);
  // next remainder step: shift in one dividend bit
  assign mod_in   = {rem_q, x_q[bit_cnt]};

  assign arm_word.remaining = TIME_BITS'(cmd.alarm_delay);
  assign arm_word.reload    = TIME_BITS'(cmd.alarm_period);
  assign arm_word.counter   = cmd.counter_id;
  assign arm_word.action    = cmd.action_kind;
  assign arm_word.target    = cmd.action_target;
  assign arm_word.evt       = cmd.event_mask;

  // operand select for the one subtractor: compare, remainder step or decrement
  always_comb begin
    unique case (state)
      ST_COUNT: begin
        sub_a = SW'(x_cmb);
        sub_b = SW'(modulus);
      end
      ST_MOD: begin
        sub_a = SW'(mod_in);
        sub_b = SW'(modulus);
      end
      ST_UPDATE: begin
        sub_a = SW'(rd_q.remaining);
        sub_b = SW'(1);
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign {sub_borrow, sub_diff} = {1'b0, sub_a} - {1'b0, sub_b};

  assign rem_next  = sub_borrow ? mod_in[MOD_W-1:0] : sub_diff[MOD_W-1:0];
  assign dec       = sub_diff[TIME_BITS-1:0];
  assign hit       = rd_q.counter == cur_cid;
  assign expire    = hit && (dec == '0);
  assign emit_ok   = expire && (res_cnt < RCNT_W'(MAX_RESULTS));
  assign out_free  = !out_vld || res.ready;
  // a second result can only move on once the output register has room
  assign upd_stall = emit_ok && pend_vld && !out_free;
  assign last_idx  = idx == AW'(NUM_ALARMS - 1);

  assign new_res.fired_alarm  = AID_W'(idx);
  assign new_res.fired_action = rd_q.action;
  assign new_res.fired_target = rd_q.target;
  assign new_res.fired_event  = (rd_q.action == ACT_SET_EVENT) ? rd_q.evt : '0;
  assign new_res.last         = 1'b0;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_fire && (cmd.kind == KIND_TICK)) state_next = ST_COUNT;
      end
      ST_COUNT: begin
        priority if (!cid_ok)                      state_next = ST_IDLE;
        else if ((modulus == '0) || sub_borrow)    state_next = ST_READ;
        else                                       state_next = ST_MOD;
      end
      ST_MOD: begin
        if (bit_cnt == '0) state_next = ST_READ;
      end
      ST_READ: begin
        priority if (active[idx]) state_next = ST_UPDATE;
        else if (last_idx)        state_next = ST_FLUSH;
        else                      state_next = ST_READ;
      end
      ST_UPDATE: begin
        priority if (upd_stall) state_next = ST_UPDATE;
        else if (last_idx)      state_next = ST_FLUSH;
        else                    state_next = ST_READ;
      end
      ST_FLUSH: begin
        if (!pend_vld || out_free) state_next = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    cmd_ready  = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = idx;
    mem_wd     = rd_q;
    act_set    = 1'b0;
    act_clr    = 1'b0;
    act_ia     = idx;
    cnt_we     = 1'b0;
    cnt_wd     = '0;
    ld_x       = 1'b0;
    mod_step   = 1'b0;
    idx_inc    = 1'b0;
    tick_start = 1'b0;
    emit_now   = 1'b0;
    flush_now  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_fire) begin
          unique case (cmd.kind)
            KIND_TICK: tick_start = 1'b1;
            KIND_ARM: begin
              if (aid_ok) begin
                mem_we  = 1'b1;
                mem_wa  = aid_idx;
                mem_wd  = arm_word;
                act_set = 1'b1;
                act_ia  = aid_idx;
              end
            end
            KIND_CANCEL: begin
              if (aid_ok) begin
                act_clr = 1'b1;
                act_ia  = aid_idx;
              end
            end
            default: ;
          endcase
        end
      end
      ST_COUNT: begin
        if (cid_ok) begin
          priority if (modulus == '0) begin
            // no modulus: wrap at the full time width
            cnt_we = 1'b1;
            cnt_wd = CW'(TIME_BITS'(x_cmb));
          end else if (sub_borrow) begin
            cnt_we = 1'b1;
            cnt_wd = CW'(x_cmb);
          end else begin
            ld_x = 1'b1;
          end
        end
      end
      ST_MOD: begin
        mod_step = 1'b1;
        if (bit_cnt == '0) begin
          cnt_we = 1'b1;
          cnt_wd = CW'(rem_next);
        end
      end
      ST_READ: begin
        idx_inc = !active[idx] && !last_idx;
      end
      ST_UPDATE: begin
        if (!upd_stall) begin
          if (hit) begin
            mem_we           = 1'b1;
            mem_wd.remaining = expire ? rd_q.reload : dec;
            // one-shot alarm goes inactive on expiry
            act_clr          = expire && (rd_q.reload == '0);
          end
          emit_now = emit_ok;
          idx_inc  = !last_idx;
        end
      end
      ST_FLUSH: begin
        flush_now = pend_vld && out_free;
      end
    endcase
  end

  assign out_load = (emit_now && pend_vld) || flush_now;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pend_vld <= 1'b0;
      out_vld  <= 1'b0;
      idx      <= '0;
      res_cnt  <= '0;
      bit_cnt  <= '0;
      for (int i = 0; i < NUM_CFG; i++) cfg_mod[i] <= MOD_RESET;
      for (int i = 0; i < NUM_COUNTERS; i++) cnt_val[i] <= '0;
      for (int i = 0; i < NUM_ALARMS; i++) active[i] <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) cfg_mod[cfg_index] <= cfg_data;
      if (cnt_we) cnt_val[ci] <= cnt_wd;
      if (act_set) active[act_ia] <= 1'b1;
      if (act_clr) active[act_ia] <= 1'b0;

      if (emit_now)       pend_vld <= 1'b1;
      else if (flush_now) pend_vld <= 1'b0;

      if (out_load)       out_vld <= 1'b1;
      else if (res.ready) out_vld <= 1'b0;

      if (tick_start)   idx <= '0;
      else if (idx_inc) idx <= AW'(idx + 1'b1);

      if (tick_start)    res_cnt <= '0;
      else if (emit_now) res_cnt <= RCNT_W'(res_cnt + 1'b1);

      if (ld_x)          bit_cnt <= BW'(XW - 1);
      else if (mod_step) bit_cnt <= BW'(bit_cnt - 1'b1);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (tick_start) cur_cid <= cmd.counter_id;
    if (ld_x) begin
      x_q   <= x_cmb;
      rem_q <= '0;
    end else if (mod_step) begin
      rem_q <= rem_next;
    end
    if (emit_now) pend <= new_res;
    if (emit_now && pend_vld) begin
      out_q <= pend;
    end else if (flush_now) begin
      // final result of the tick carries last
      out_q <= '{fired_alarm:  pend.fired_alarm,
                 fired_action: pend.fired_action,
                 fired_target: pend.fired_target,
                 fired_event:  pend.fired_event,
                 last:         1'b1};
    end
  end

  // alarm table memory, registered read at the walk index
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[idx];
  end

  assign cmd.ready        = cmd_ready;
  assign res.valid        = out_vld;
  assign res.fired_alarm  = out_q.fired_alarm;
  assign res.fired_action = out_q.fired_action;
  assign res.fired_target = out_q.fired_target;
  assign res.fired_event  = out_q.fired_event;
  assign res.last         = out_q.last;

endmodule

[hw/rtl/catk_checker.sv]
`timescale 1ns / 1ps

module catk_checker import catk_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              cmd_valid,
  input logic              cmd_ready,
  input logic [KIND_W-1:0] cmd_kind,
  input logic              res_valid,
  input logic              res_ready,
  input logic [AID_W-1:0]  res_fired_alarm,
  input logic [EVT_W-1:0]  res_fired_event,
  input logic              res_last
);

  // a tick keeps the block busy for at least the next cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (cmd_kind == KIND_TICK) |=> !cmd_ready)
    else $error("ready stayed high after a tick transfer");

  // while a tick still has results to come the block takes no new item
  a_busy_mid_tick: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_last |-> !cmd_ready)
    else $error("ready high while a non-final result is pending");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_fired_alarm)
      && $stable(res_fired_event) && $stable(res_last))
    else $error("stalled result changed");

endmodule

bind counter_alarm_tick_engine catk_checker u_catk_checker (
  .clk             (clk),
  .rst             (rst),
  .cmd_valid       (cmd.valid),
  .cmd_ready       (cmd.ready),
  .cmd_kind        (cmd.kind),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .res_fired_alarm (res.fired_alarm),
  .res_fired_event (res.fired_event),
  .res_last        (res.last)
);
